### hdl/wtw_pkg.sv
package wtw_pkg;

   localparam int TIME_WIDTH     = 40;
   localparam int BIAS_WIDTH     = 41;
   localparam int SEC_WIDTH      = 17;
   localparam int DAY_SECONDS    = 86400;
   localparam int LOW_BITS       = 7;
   localparam int DAY_UNITS      = 675;
   localparam int WEEK_DAYS      = 7;
   localparam int WEEK_UNITS     = DAY_UNITS * WEEK_DAYS;
   localparam int REM_WIDTH      = 13;
   localparam int DAY_WIDTH      = 3;
   localparam int EPOCH_WEEKDAY  = 4;
   localparam int STEP_BITS      = 7;
   localparam int DIV_STAGES     = 5;
   localparam int QUO_WIDTH      = STEP_BITS * DIV_STAGES;

   // whole number of weeks of seconds, at least 2^39: keeps the biased time positive
   localparam logic [BIAS_WIDTH-1:0] TIME_BIAS = 41'd549777110400;

   localparam int RULE_REGS      = 4;
   localparam int RULE_WIDTH     = 42;
   localparam int COUNT_WIDTH    = 3;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_LSB  = 3;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RULE_COUNT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RULE_BASE  = 3'd1;

   localparam logic [1:0] LEVEL_OFF  = 2'd0;
   localparam logic [1:0] LEVEL_ON   = 2'd1;
   localparam logic [1:0] LEVEL_NONE = 2'd2;

   typedef struct packed {
      logic                 enable;
      logic [6:0]           days;
      logic [SEC_WIDTH-1:0] off_sec;
      logic [SEC_WIDTH-1:0] on_sec;
   } wtw_rule_type;

   typedef struct packed {
      logic [QUO_WIDTH-1:0] dividend;
      logic [LOW_BITS-1:0]  low;
      logic [REM_WIDTH-1:0] rem;
   } wtw_div_type;

   typedef struct packed {
      logic [SEC_WIDTH-1:0] sec;
      logic [DAY_WIDTH-1:0] wd_today;
      logic [DAY_WIDTH-1:0] wd_prev;
   } wtw_day_type;

endpackage

### hdl/wtw_csr.sv
module wtw_csr
   import wtw_pkg::*;
#(
   parameter int NUM_RULES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic [COUNT_WIDTH-1:0]    rule_count,
   output wtw_rule_type              rules [NUM_RULES]
);

   localparam int STORED = (NUM_RULES < RULE_REGS) ? NUM_RULES : RULE_REGS;

   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic                       wr_en;
   logic [COUNT_WIDTH-1:0]     rule_count_ff;
   wtw_rule_type               rule_ff [STORED];

   assign reg_index  = paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB];
   assign wr_en      = psel && penable && pwrite;
   assign rule_count = rule_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
         for (int r = 0; r < STORED; r++) begin
            rule_ff[r] <= '0;
         end
      end else if (wr_en) begin
         if (reg_index == CSR_RULE_COUNT) begin
            rule_count_ff <= pwdata[COUNT_WIDTH-1:0];
         end
         for (int r = 0; r < STORED; r++) begin
            if (reg_index == CSR_RULE_BASE + CSR_INDEX_WIDTH'(r)) begin
               rule_ff[r] <= pwdata[RULE_WIDTH-1:0];
            end
         end
      end
   end

   for (genvar g = 0; g < NUM_RULES; g++) begin : g_rules
      if (g < STORED) begin : g_reg
         assign rules[g] = rule_ff[g];
      end else begin : g_zero
         assign rules[g] = '0;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == CSR_RULE_COUNT) begin
         prdata = CSR_DATA_WIDTH'(rule_count_ff);
      end
      for (int r = 0; r < STORED; r++) begin
         if (reg_index == CSR_RULE_BASE + CSR_INDEX_WIDTH'(r)) begin
            prdata = CSR_DATA_WIDTH'(rule_ff[r]);
         end
      end
   end

endmodule

### hdl/wtw_div_stage.sv
module wtw_div_stage
   import wtw_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        valid_in,
   input  wtw_div_type data_in,
   output logic        valid_out,
   output wtw_div_type data_out
);

   logic        valid_ff;
   wtw_div_type data_ff;
   wtw_div_type data_in_w;

   // remainder of the day-unit count modulo one week, one bit per step
   always_comb begin
      logic [REM_WIDTH:0]   trial;
      logic [REM_WIDTH-1:0] rem_w;
      rem_w = data_in.rem;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {rem_w, data_in.dividend[QUO_WIDTH-1-STAGE*STEP_BITS-i]};
         if (trial >= (REM_WIDTH+1)'(WEEK_UNITS)) begin
            rem_w = REM_WIDTH'(trial - (REM_WIDTH+1)'(WEEK_UNITS));
         end else begin
            rem_w = REM_WIDTH'(trial);
         end
      end
      data_in_w     = data_in;
      data_in_w.rem = rem_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.rem < REM_WIDTH'(WEEK_UNITS))
      else $error("remainder out of range");

endmodule

### hdl/wtw_day_decode.sv
module wtw_day_decode
   import wtw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        valid_in,
   input  wtw_div_type data_in,
   output logic        valid_out,
   output wtw_day_type day_out
);

   logic        valid_ff;
   wtw_day_type day_ff;
   wtw_day_type day_in;

   always_comb begin
      logic [DAY_WIDTH-1:0] idx;
      logic [REM_WIDTH-1:0] base;
      logic [REM_WIDTH-1:0] hi;
      logic [DAY_WIDTH:0]   wt;
      idx  = '0;
      base = '0;
      for (int k = 1; k < WEEK_DAYS; k++) begin
         if (data_in.rem >= REM_WIDTH'(k * DAY_UNITS)) begin
            idx  = DAY_WIDTH'(k);
            base = REM_WIDTH'(k * DAY_UNITS);
         end
      end
      hi = data_in.rem - base;
      wt = (DAY_WIDTH+1)'(idx) + (DAY_WIDTH+1)'(EPOCH_WEEKDAY);
      if (wt >= (DAY_WIDTH+1)'(WEEK_DAYS)) begin
         wt = wt - (DAY_WIDTH+1)'(WEEK_DAYS);
      end
      day_in.sec      = SEC_WIDTH'({hi, data_in.low});
      day_in.wd_today = DAY_WIDTH'(wt);
      if (wt == '0) begin
         day_in.wd_prev = DAY_WIDTH'(WEEK_DAYS - 1);
      end else begin
         day_in.wd_prev = DAY_WIDTH'(wt - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         day_ff <= day_in;
      end
   end

   assign valid_out = valid_ff;
   assign day_out   = day_ff;

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (day_ff.sec < SEC_WIDTH'(DAY_SECONDS))
                   && (day_ff.wd_today < DAY_WIDTH'(WEEK_DAYS))
                   && (day_ff.wd_prev < DAY_WIDTH'(WEEK_DAYS)))
      else $error("second of day or weekday out of range");

endmodule

### hdl/wtw_rule_eval.sv
module wtw_rule_eval
   import wtw_pkg::*;
#(
   parameter int NUM_RULES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_in,
   input  wtw_day_type            day_in,
   input  logic [COUNT_WIDTH-1:0] rule_count,
   input  wtw_rule_type           rules [NUM_RULES],
   output logic                   valid_out,
   output logic [1:0]             level_out
);

   logic                   valid_ff;
   logic [1:0]             level_ff;
   logic [1:0]             level_in;
   logic [COUNT_WIDTH-1:0] n_eff;

   assign n_eff = (rule_count > COUNT_WIDTH'(NUM_RULES)) ? COUNT_WIDTH'(NUM_RULES) : rule_count;

   always_comb begin
      logic any_live;
      logic any_on;
      logic live;
      logic overnight;
      logic hit_prev;
      logic hit_today;
      any_live = 1'b0;
      any_on   = 1'b0;
      for (int i = 0; i < NUM_RULES; i++) begin
         live = (COUNT_WIDTH'(i) < n_eff) && rules[i].enable && (rules[i].days != '0)
                && (rules[i].on_sec < SEC_WIDTH'(DAY_SECONDS))
                && (rules[i].off_sec < SEC_WIDTH'(DAY_SECONDS));
         overnight = rules[i].off_sec <= rules[i].on_sec;
         hit_prev  = rules[i].days[day_in.wd_prev] && overnight
                     && (day_in.sec < rules[i].off_sec);
         hit_today = rules[i].days[day_in.wd_today] && (day_in.sec >= rules[i].on_sec)
                     && (overnight || (day_in.sec < rules[i].off_sec));
         any_live  = any_live | live;
         any_on    = any_on | (live && (hit_prev || hit_today));
      end
      if (any_on) begin
         level_in = LEVEL_ON;
      end else if (any_live) begin
         level_in = LEVEL_OFF;
      end else begin
         level_in = LEVEL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
      end
   end

   assign valid_out = valid_ff;
   assign level_out = level_ff;

   a_no_rules: assert property (@(posedge clock) disable iff (reset)
      valid_in && advance && (n_eff == '0) |=> level_ff == LEVEL_NONE)
      else $error("level not none with no rules in use");

endmodule

### hdl/weekly_timer_window_check_unit.sv
// Pipeline from the accepted req_ word to rsp_valid: offset add, five divider
// stages of 7 quotient bits each, day decode, rule compare, each one registered.
// Throughput: one word per cycle; the whole pipeline holds while rsp_valid waits.
// Reset: synchronous, active high; clears the pipeline valid bits, rule_count
// and all rule registers.
module weekly_timer_window_check_unit
   import wtw_pkg::*;
#(
   parameter int NUM_RULES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [TIME_WIDTH-1:0] req_local_seconds,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_level,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic                   advance;
   logic [BIAS_WIDTH-1:0]  biased;
   logic                   entry_valid_ff;
   wtw_div_type            entry_ff;
   wtw_div_type            entry_in;
   logic                   div_valid [DIV_STAGES+1];
   wtw_div_type            div_data  [DIV_STAGES+1];
   logic                   day_valid;
   wtw_day_type            day_data;
   logic [COUNT_WIDTH-1:0] rule_count;
   wtw_rule_type           rules [NUM_RULES];

   assign pready    = 1'b1;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign biased = {req_local_seconds[TIME_WIDTH-1], req_local_seconds} + TIME_BIAS;

   always_comb begin
      entry_in.dividend = QUO_WIDTH'(biased[BIAS_WIDTH-1:LOW_BITS]);
      entry_in.low      = biased[LOW_BITS-1:0];
      entry_in.rem      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign div_valid[0] = entry_valid_ff;
   assign div_data[0]  = entry_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      wtw_div_stage #(
         .STAGE(s)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (div_valid[s]),
         .data_in  (div_data[s]),
         .valid_out(div_valid[s+1]),
         .data_out (div_data[s+1])
      );
   end

   wtw_day_decode u_day (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_in (div_valid[DIV_STAGES]),
      .data_in  (div_data[DIV_STAGES]),
      .valid_out(day_valid),
      .day_out  (day_data)
   );

   wtw_csr #(
      .NUM_RULES(NUM_RULES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .rule_count(rule_count),
      .rules     (rules)
   );

   wtw_rule_eval #(
      .NUM_RULES(NUM_RULES)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (day_valid),
      .day_in    (day_data),
      .rule_count(rule_count),
      .rules     (rules),
      .valid_out (rsp_valid),
      .level_out (rsp_level)
   );

endmodule
